FILE: sv/imu_fp_pkg.sv
// ---------------------------------------------------------------------------
// IMU frame pair parser package
// Shared constants, frame codes and the result item type.
// ---------------------------------------------------------------------------
package imu_fp_pkg;

  // Payload framing: two frames of eleven bytes each.
  localparam logic [4:0] PayloadLen = 5'd22;
  localparam logic [4:0] FrameLen   = 5'd11;

  // Byte offsets inside one frame.
  localparam logic [3:0] OffHeader   = 4'd0;
  localparam logic [3:0] OffType     = 4'd1;
  localparam logic [3:0] OffLow0     = 4'd2;
  localparam logic [3:0] OffHigh0    = 4'd3;
  localparam logic [3:0] OffLow1     = 4'd4;
  localparam logic [3:0] OffHigh1    = 4'd5;
  localparam logic [3:0] OffLow2     = 4'd6;
  localparam logic [3:0] OffHigh2    = 4'd7;
  localparam logic [3:0] OffChecksum = 4'd10;

  // Frame header and type bytes.
  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeRate  = 8'h52;

  // What the current frame has shown so far.
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindHdr   = 2'd1;
  localparam logic [1:0] KindAngle = 2'd2;
  localparam logic [1:0] KindRate  = 2'd3;

  // One result item.
  typedef struct packed {
    logic               angle_found;
    logic               gyro_found;
    logic               frame_valid;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } result_t;

endpackage

FILE: sv/imu_frame_pair_parser.sv
// Path: the 22nd byte is held in the input register, and its result item is
// loaded into the result register when the core consumes that byte.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so bytes keep flowing while a result waits and
// only the 22nd byte of the next payload waits for the result register.
// Reset: asynchronous, active low; the block then ignores bytes until one
// arrives with payload_start_i set.
// ---------------------------------------------------------------------------
// IMU frame pair parser, top level
// Parses a 22-byte payload as two frames, each an angle or an angular rate frame.
// ---------------------------------------------------------------------------
module imu_frame_pair_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               payload_start_i,
  // Result output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               angle_found_o,
  output logic               gyro_found_o,
  output logic               frame_valid_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o
);

  // Input register: holds one accepted item until the core consumes it.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       start_q;

  // Result register.
  logic                out_valid_q, out_valid_d;
  imu_fp_pkg::result_t res_q;

  logic                advance;
  logic                emit;
  imu_fp_pkg::result_t res_c;

  // The core may consume the held item whenever the result register is free
  // or is being emptied this cycle; items that give no result never wait.
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  imu_fp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .data_byte_i     (byte_q),
    .payload_start_i (start_q),
    .emit_o          (emit),
    .result_o        (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      start_q <= payload_start_i;
    end
    if (advance && emit) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_found_o = res_q.angle_found;
  assign gyro_found_o  = res_q.gyro_found;
  assign frame_valid_o = res_q.frame_valid;
  assign roll_angle_o  = res_q.roll_angle;
  assign pitch_angle_o = res_q.pitch_angle;
  assign yaw_angle_o   = res_q.yaw_angle;
  assign rate_x_o      = res_q.rate_x;
  assign rate_y_o      = res_q.rate_y;
  assign rate_z_o      = res_q.rate_z;

endmodule

FILE: sv/imu_fp_parser.sv
// ---------------------------------------------------------------------------
// IMU frame pair parser core
// Holds the payload state and decodes one byte per enabled cycle.
// ---------------------------------------------------------------------------
module imu_fp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 payload_start_i,
  output logic                 emit_o,
  output imu_fp_pkg::result_t  result_o
);

  logic [4:0]       pos_q, pos_d, pos_c, h_wide;
  logic [3:0]       h;
  logic [7:0]       sum_q, sum_d;
  logic [1:0]       kind_q, kind_d, kind_c;
  logic [7:0]       low_q, low_d;
  logic [2:0][15:0] half_q, half_d;
  logic [2:0][15:0] angle_q, angle_d;
  logic [2:0][15:0] rate_q, rate_d;
  logic [1:0]       flags_q, flags_d, flags_c;
  logic             active;

  always_comb begin
    // A start byte restarts the payload at this very byte.
    pos_c   = payload_start_i ? 5'd0 : pos_q;
    flags_c = payload_start_i ? 2'b00 : flags_q;
    kind_c  = payload_start_i ? imu_fp_pkg::KindNone : kind_q;
    active  = pos_c < imu_fp_pkg::PayloadLen;
    h_wide  = (pos_c >= imu_fp_pkg::FrameLen) ? (pos_c - imu_fp_pkg::FrameLen) : pos_c;
    h       = h_wide[3:0];

    pos_d   = pos_c;
    sum_d   = sum_q;
    kind_d  = kind_c;
    low_d   = low_q;
    half_d  = half_q;
    angle_d = angle_q;
    rate_d  = rate_q;
    flags_d = flags_c;

    if (active) begin
      pos_d = pos_c + 5'd1;
      case (h)
        imu_fp_pkg::OffHeader: begin
          kind_d = (data_byte_i == imu_fp_pkg::HdrByte) ? imu_fp_pkg::KindHdr
                                                         : imu_fp_pkg::KindNone;
          sum_d  = data_byte_i;
        end
        imu_fp_pkg::OffChecksum: begin
          if ((kind_c == imu_fp_pkg::KindAngle || kind_c == imu_fp_pkg::KindRate) &&
              sum_q == data_byte_i) begin
            if (kind_c == imu_fp_pkg::KindAngle) begin
              angle_d    = half_q;
              flags_d[0] = 1'b1;
            end else begin
              rate_d     = half_q;
              flags_d[1] = 1'b1;
            end
          end
        end
        default: begin
          sum_d = sum_q + data_byte_i;
          case (h)
            imu_fp_pkg::OffType: begin
              if (kind_c == imu_fp_pkg::KindHdr && data_byte_i == imu_fp_pkg::TypeAngle) begin
                kind_d = imu_fp_pkg::KindAngle;
              end else if (kind_c == imu_fp_pkg::KindHdr &&
                           data_byte_i == imu_fp_pkg::TypeRate) begin
                kind_d = imu_fp_pkg::KindRate;
              end else begin
                kind_d = imu_fp_pkg::KindNone;
              end
            end
            imu_fp_pkg::OffLow0, imu_fp_pkg::OffLow1, imu_fp_pkg::OffLow2: begin
              low_d = data_byte_i;
            end
            imu_fp_pkg::OffHigh0: half_d[0] = {data_byte_i, low_q};
            imu_fp_pkg::OffHigh1: half_d[1] = {data_byte_i, low_q};
            imu_fp_pkg::OffHigh2: half_d[2] = {data_byte_i, low_q};
            default: ;
          endcase
        end
      endcase
    end

    emit_o = active && (pos_c == imu_fp_pkg::PayloadLen - 5'd1);

    // Triples of a type that was not found read as zero.
    result_o.angle_found = flags_d[0];
    result_o.gyro_found  = flags_d[1];
    result_o.frame_valid = |flags_d;
    result_o.roll_angle  = flags_d[0] ? angle_d[0] : 16'sd0;
    result_o.pitch_angle = flags_d[0] ? angle_d[1] : 16'sd0;
    result_o.yaw_angle   = flags_d[0] ? angle_d[2] : 16'sd0;
    result_o.rate_x      = flags_d[1] ? rate_d[0] : 16'sd0;
    result_o.rate_y      = flags_d[1] ? rate_d[1] : 16'sd0;
    result_o.rate_z      = flags_d[1] ? rate_d[2] : 16'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= imu_fp_pkg::PayloadLen;
      sum_q   <= '0;
      kind_q  <= imu_fp_pkg::KindNone;
      flags_q <= '0;
    end else if (en_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      kind_q  <= kind_d;
      flags_q <= flags_d;
    end
  end

  // Value registers carry no reset; values reach the result only once the matching flag is set.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      low_q   <= low_d;
      half_q  <= half_d;
      angle_q <= angle_d;
      rate_q  <= rate_d;
    end
  end

endmodule

FILE: sv/imu_fp_checker.sv
// ---------------------------------------------------------------------------
// IMU frame pair parser checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module imu_fp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               angle_found_o,
  input logic               gyro_found_o,
  input logic               frame_valid_o,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] pitch_angle_o,
  input logic signed [15:0] yaw_angle_o,
  input logic signed [15:0] rate_x_o,
  input logic signed [15:0] rate_y_o,
  input logic signed [15:0] rate_z_o
);

  // A stalled result item stays valid; its found flags, roll angle and rate_z stay unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_found_o) &&
      $stable(gyro_found_o) && $stable(roll_angle_o) && $stable(rate_z_o))
    else $error("result item changed while stalled");

  // The summary flag follows the two found flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_valid_o == (angle_found_o || gyro_found_o))
    else $error("frame_valid disagrees with found flags");

  // Angles of a payload without an angle frame read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !angle_found_o |->
      roll_angle_o == 16'sd0 && pitch_angle_o == 16'sd0 && yaw_angle_o == 16'sd0)
    else $error("angles not zero without an angle frame");

  // Rates of a payload without a rate frame read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gyro_found_o |->
      rate_x_o == 16'sd0 && rate_y_o == 16'sd0 && rate_z_o == 16'sd0)
    else $error("rates not zero without a rate frame");

endmodule

bind imu_frame_pair_parser imu_fp_checker u_imu_fp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .angle_found_o (angle_found_o),
  .gyro_found_o  (gyro_found_o),
  .frame_valid_o (frame_valid_o),
  .roll_angle_o  (roll_angle_o),
  .pitch_angle_o (pitch_angle_o),
  .yaw_angle_o   (yaw_angle_o),
  .rate_x_o      (rate_x_o),
  .rate_y_o      (rate_y_o),
  .rate_z_o      (rate_z_o)
);

FILE: verif/imu_fp_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU frame pair parser scoreboard
// Tracks the payload parse for every accepted byte and checks result items.
// ---------------------------------------------------------------------------
package imu_fp_tb_pkg;

  import imu_fp_pkg::*;

  localparam int unsigned ReportLimit = 10;

  class imu_pair_scoreboard;

    logic [4:0]  byte_pos;
    logic [7:0]  frame_sum;
    logic [1:0]  frame_kind;
    logic [7:0]  low_hold;
    logic [15:0] frame_vals [3];
    logic [15:0] angle_vals [3];
    logic [15:0] rate_vals [3];
    logic [1:0]  found;
    result_t     pending [$];
    int unsigned errors;

    function new();
      errors = 0;
      byte_pos = PayloadLen;
      clear_payload();
    endfunction

    function void clear_payload();
      frame_sum  = '0;
      frame_kind = KindNone;
      low_hold   = '0;
      found      = '0;
      for (int k = 0; k < 3; k++) begin
        frame_vals[k] = '0;
        angle_vals[k] = '0;
        rate_vals[k]  = '0;
      end
    endfunction

    // Advances the parse by one accepted byte. Returns 1 if the byte was
    // taken into a payload, 0 if the parser was waiting for a start byte.
    function bit note_byte(logic [7:0] b, logic start);
      logic [3:0] offs;
      result_t    res;
      if (start) begin
        clear_payload();
        byte_pos = '0;
      end
      if (byte_pos >= PayloadLen) return 1'b0;
      offs = (byte_pos >= FrameLen) ? 4'(byte_pos - FrameLen) : 4'(byte_pos);
      if (offs == OffHeader) begin
        frame_kind = (b == HdrByte) ? KindHdr : KindNone;
        frame_sum  = b;
      end else if (offs == OffChecksum) begin
        if (frame_kind >= KindAngle && frame_sum == b) begin
          for (int k = 0; k < 3; k++) begin
            if (frame_kind == KindAngle) angle_vals[k] = frame_vals[k];
            else rate_vals[k] = frame_vals[k];
          end
          found |= (frame_kind == KindAngle) ? 2'b01 : 2'b10;
        end
      end else begin
        frame_sum = frame_sum + b;
        if (offs == OffType) begin
          if (frame_kind == KindHdr && b == TypeAngle) frame_kind = KindAngle;
          else if (frame_kind == KindHdr && b == TypeRate) frame_kind = KindRate;
          else frame_kind = KindNone;
        end else if (offs <= OffHigh2) begin
          if (!offs[0]) low_hold = b;
          else frame_vals[(offs - OffHigh0) / 2] = {b, low_hold};
        end
      end
      if (byte_pos == PayloadLen - 1) begin
        res.angle_found = found[0];
        res.gyro_found  = found[1];
        res.frame_valid = |found;
        res.roll_angle  = found[0] ? angle_vals[0] : '0;
        res.pitch_angle = found[0] ? angle_vals[1] : '0;
        res.yaw_angle   = found[0] ? angle_vals[2] : '0;
        res.rate_x      = found[1] ? rate_vals[0] : '0;
        res.rate_y      = found[1] ? rate_vals[1] : '0;
        res.rate_z      = found[1] ? rate_vals[2] : '0;
        pending.push_back(res);
      end
      byte_pos = byte_pos + 1'b1;
      return 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        if (errors < ReportLimit)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        if (errors < ReportLimit)
          $display("unexpected result item: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("angle_found", 16'(want.angle_found), 16'(got.angle_found));
      check_field("gyro_found", 16'(want.gyro_found), 16'(got.gyro_found));
      check_field("frame_valid", 16'(want.frame_valid), 16'(got.frame_valid));
      check_field("roll_angle", want.roll_angle, got.roll_angle);
      check_field("pitch_angle", want.pitch_angle, got.pitch_angle);
      check_field("yaw_angle", want.yaw_angle, got.yaw_angle);
      check_field("rate_x", want.rate_x, got.rate_x);
      check_field("rate_y", want.rate_y, got.rate_y);
      check_field("rate_z", want.rate_z, got.rate_z);
    endfunction

  endclass

endpackage

FILE: verif/tb_imu_frame_pair_parser.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// IMU frame pair parser testbench
// Streams well-formed, damaged and truncated payloads with random idling on
// both channels and checks every result item against a parse model.
// ---------------------------------------------------------------------------
module tb_imu_frame_pair_parser;

  import imu_fp_pkg::*;
  import imu_fp_tb_pkg::*;

  // Roughly how many bytes the parser should actually take in.
  localparam int unsigned ByteTarget = 950;
  // A result item passes the input and result registers after the last byte.
  localparam int unsigned DrainCycles = 20;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned WatchdogLimit = 5000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               payload_start_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               angle_found_o;
  logic               gyro_found_o;
  logic               frame_valid_o;
  logic signed [15:0] roll_angle_o;
  logic signed [15:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic signed [15:0] rate_x_o;
  logic signed [15:0] rate_y_o;
  logic signed [15:0] rate_z_o;

  imu_frame_pair_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .payload_start_i (payload_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .angle_found_o   (angle_found_o),
    .gyro_found_o    (gyro_found_o),
    .frame_valid_o   (frame_valid_o),
    .roll_angle_o    (roll_angle_o),
    .pitch_angle_o   (pitch_angle_o),
    .yaw_angle_o     (yaw_angle_o),
    .rate_x_o        (rate_x_o),
    .rate_y_o        (rate_y_o),
    .rate_z_o        (rate_z_o)
  );

  imu_pair_scoreboard sb = new();

  // Percentages of cycles in which each side holds back.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Bytes the parser took into a payload; ignored bytes are not counted.
  int unsigned taken_bytes;
  int unsigned quiet_cycles;
  // The payload being built before it is streamed out.
  logic [7:0]  payload_buf [22];

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  // The receiver decides its ready at each falling edge, so it never changes
  // close to the rising edge that samples it.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result items are sampled at the rising edge and compared in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({angle_found_o, gyro_found_o, frame_valid_o, roll_angle_o,
                       pitch_angle_o, yaw_angle_o, rate_x_o, rate_y_o, rate_z_o});
    end
  end

  // The watchdog restarts on every handshake of either channel. A run that
  // goes quiet this long has hung, whatever the idling.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one byte. Called just after a falling edge and returns just after
  // the falling edge that follows its acceptance. Valid is left high so the
  // next byte can follow without a gap; it only drops when the sender idles.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    payload_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (sb.note_byte(b, start)) taken_bytes++;
    @(negedge clk_i);
  endtask

  // Fills one eleven-byte frame with a header, a type byte, three values,
  // two filler bytes and the matching checksum.
  task automatic set_frame(input int base, input logic [7:0] kind_byte,
                           input logic [15:0] v0, input logic [15:0] v1,
                           input logic [15:0] v2);
    logic [7:0] sum;
    payload_buf[base]     = HdrByte;
    payload_buf[base + 1] = kind_byte;
    payload_buf[base + 2] = v0[7:0];
    payload_buf[base + 3] = v0[15:8];
    payload_buf[base + 4] = v1[7:0];
    payload_buf[base + 5] = v1[15:8];
    payload_buf[base + 6] = v2[7:0];
    payload_buf[base + 7] = v2[15:8];
    payload_buf[base + 8] = 8'($urandom);
    payload_buf[base + 9] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < 10; i++) sum = sum + payload_buf[base + i];
    payload_buf[base + 10] = sum;
  endtask

  // Builds a random frame. Most frames are well formed so that the parse
  // reaches the checksum; a few get a bad header, an unknown type or a bad
  // checksum. Values lean toward the signed extremes now and then.
  task automatic build_frame(input int base);
    logic [7:0]  kind_byte;
    logic [15:0] vals [3];
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) kind_byte = TypeAngle;
    else if (roll < 90) kind_byte = TypeRate;
    else kind_byte = 8'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(9))
        0: vals[k] = 16'h8000;
        1: vals[k] = 16'h7fff;
        2: vals[k] = 16'h0000;
        3: vals[k] = 16'hffff;
        default: vals[k] = 16'($urandom);
      endcase
    end
    set_frame(base, kind_byte, vals[0], vals[1], vals[2]);
    roll = $urandom_range(99);
    if (roll < 5) begin
      payload_buf[base] = 8'($urandom);
    end else if (roll < 15) begin
      payload_buf[base + 10] = payload_buf[base + 10] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // Streams one payload. Now and then stray bytes come first, the payload is
  // cut short, a start byte lands in the middle to resynchronize, or stray
  // bytes trail after the last payload byte.
  task automatic send_payload();
    int cut;
    int resync;
    build_frame(0);
    build_frame(11);
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
    cut    = ($urandom_range(19) == 0) ? $urandom_range(1, 21) : 22;
    resync = ($urandom_range(19) == 0) ? $urandom_range(1, 21) : -1;
    for (int i = 0; i < cut; i++) begin
      send_byte(payload_buf[i], (i == 0) || (i == resync));
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    payload_start_i = 1'b0;
    out_ready_i     = 1'b0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    taken_bytes     = 0;
    quiet_cycles    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: bytes before any start byte must be ignored, then one
    // clean payload carries both signed extremes in the angle triple and the most negative value in the rate triple.
    send_byte(8'hff, 1'b0);
    send_byte(HdrByte, 1'b0);
    set_frame(0, TypeAngle, 16'h8000, 16'h7fff, 16'hffff);
    set_frame(11, TypeRate, 16'h0000, 16'h0001, 16'h8000);
    for (int i = 0; i < 22; i++) send_byte(payload_buf[i], i == 0);

    // Random part in three idling phases. At the end of each phase the
    // sender stops until every expected result item has come back.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 67;
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (taken_bytes < (ph + 1) * ByteTarget / 3) send_payload();
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (sb.pending.size() != 0) @(negedge clk_i);
    end

    // Let any stray result item surface before the verdict.
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/imu_fp_pkg.sv
sv/imu_fp_parser.sv
sv/imu_frame_pair_parser.sv
sv/imu_fp_checker.sv
verif/imu_fp_tb_pkg.sv
verif/tb_imu_frame_pair_parser.sv
